/* sv/dupr_pkg.sv */
package dupr_pkg;

    localparam int MaxRowsDef = 256;
    localparam int MaxColsDef = 8;

    localparam int RegRowWidth = 0;
    localparam logic [3:0] RowWidthReset = 4'd1;

    typedef struct packed {
        logic [63:0] value;
        logic        end_of_matrix;
    } t_in;

    typedef struct packed {
        logic duplicate;
        logic table_full;
    } t_out;

    // Column match: the double difference is zero or NaN.
    // Holds when either side is NaN, when the bits are equal (this covers
    // same-signed infinities), or when both are zeros of any sign.
    function automatic logic col_match(input logic [63:0] a, input logic [63:0] b);
        logic a_nan;
        logic b_nan;
        logic zeros;
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        zeros = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        return a_nan || b_nan || zeros || (a == b);
    endfunction

endpackage

/* sv/dupr_row_mem.sv */
module dupr_row_mem import dupr_pkg::*; #(
    parameter int MAX_ROWS = MaxRowsDef,
    parameter int MAX_COLS = MaxColsDef,
    localparam int AW = $clog2(MAX_ROWS)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [MAX_COLS*64-1:0]   i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [MAX_COLS*64-1:0]   o_rd_data
);

    logic [MAX_COLS*64-1:0] mem [MAX_ROWS];
    logic [MAX_COLS*64-1:0] r_rd_data;

    // One row per entry: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/dupr_row_cmp.sv */
module dupr_row_cmp import dupr_pkg::*; #(
    parameter int MAX_COLS = MaxColsDef,
    localparam int WW = (MAX_COLS > 1 ? $clog2(MAX_COLS) : 1) + 1
) (
    input  logic [MAX_COLS*64-1:0] i_row_a,
    input  logic [MAX_COLS*64-1:0] i_row_b,
    input  logic [WW-1:0]          i_width,
    output logic                   o_match
);

    logic [MAX_COLS-1:0] col_ok;

    // Check every column in use; columns past the width always pass
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_ok[c] = (WW'(c) >= i_width) ||
                        col_match(i_row_a[c*64 +: 64], i_row_b[c*64 +: 64]);
        end
    end

    assign o_match = &col_ok;

endmodule

/* sv/duplicate_row_detector.sv */
// Channel | Direction | Handshake                 | Beat
// in      | input     | i_in_valid / o_in_stall   | t_in  (value, end_of_matrix)
// out     | output    | o_out_valid / i_out_stall | t_out (duplicate, table_full)
// cfg     | input     | APB psel/penable/pwrite   | row_width at byte 0
//
// An element that does not end a row is stored and the sequencer stays idle. A
// row-ending element is accepted, then the N rows stored so far are scanned
// through the single read port, a READ and a CMP state per stored row, until a
// match; a final READ closes the scan and DONE reports.
// Reset clears the control state only; no clearing pass runs on the memory.
// A held result does not block the next beat; the result register stalls the
// next row-ending element only until the previous result is taken.
module duplicate_row_detector import dupr_pkg::*; #(
    parameter int MAX_ROWS = MaxRowsDef,
    parameter int MAX_COLS = MaxColsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int WW = CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_col;
    logic [AW:0]            r_row;
    logic [AW:0]            r_stored;
    logic                   r_eom;
    logic                   r_dup;
    logic [3:0]             r_width;
    logic [63:0]            r_cur [MAX_COLS];
    logic                   r_out_valid;
    t_out                   r_out;

    logic [WW-1:0]          width_eff;
    logic [WW-1:0]          col_next;
    logic [MAX_COLS*64-1:0] cur_flat;
    logic [MAX_COLS*64-1:0] wr_data;
    logic [MAX_COLS*64-1:0] rd_data;
    logic                   row_match;
    logic                   in_acc;
    logic                   cfg_wr;
    logic                   rd_en;
    logic                   wr_en;
    logic                   done_go;
    logic                   has_room;

    // Clamp the register to 1..MAX_COLS
    always_comb begin
        if (r_width == 4'd0) begin
            width_eff = WW'(1);
        end else if (int'(r_width) > MAX_COLS) begin
            width_eff = WW'(MAX_COLS);
        end else begin
            width_eff = WW'(r_width);
        end
    end

    // Flatten the current row; zero unused columns for the store
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            cur_flat[c*64 +: 64] = r_cur[c];
            wr_data[c*64 +: 64]  = (WW'(c) < width_eff) ? r_cur[c] : 64'd0;
        end
    end

    assign col_next = WW'(r_col) + WW'(1);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign has_room = (r_stored < (AW+1)'(MAX_ROWS));
    assign rd_en    = (r_state == S_READ) && (r_row < r_stored);
    assign done_go  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign wr_en    = done_go && !r_dup && has_room;

    dupr_row_mem #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_stored[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_row[AW-1:0]),
        .o_rd_data (rd_data)
    );

    dupr_row_cmp #(
        .MAX_COLS (MAX_COLS)
    ) u_cmp (
        .i_row_a (rd_data),
        .i_row_b (cur_flat),
        .i_width (width_eff),
        .o_match (row_match)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'(RegRowWidth)) ? {28'd0, r_width} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RowWidthReset;
        end else if (cfg_wr && paddr[2] == 1'(RegRowWidth)) begin
            r_width <= pwdata[3:0];
        end
    end

    // Hold the incoming row elements
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur[r_col] <= i_in_data.value;
        end
    end

    // Sequencer: collect, scan stored rows, decide, report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_stored    <= '0;
            r_eom       <= 1'b0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (col_next >= width_eff) begin
                            r_col   <= '0;
                            r_eom   <= i_in_data.end_of_matrix;
                            r_row   <= '0;
                            r_dup   <= 1'b0;
                            r_state <= S_READ;
                        end else begin
                            r_col <= col_next[CW-1:0];
                        end
                    end
                end
                S_READ: begin
                    r_state <= rd_en ? S_CMP : S_DONE;
                end
                S_CMP: begin
                    if (row_match) begin
                        r_dup   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (done_go) begin
                        r_out_valid      <= 1'b1;
                        r_out.duplicate  <= r_dup;
                        r_out.table_full <= !r_dup && !has_room;
                        if (r_eom) begin
                            r_stored <= '0;
                        end else if (wr_en) begin
                            r_stored <= r_stored + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
